// ===== hw/rtl/alegp_pkg.sv =====
// Shared types, constants and helper functions of the associated Legendre evaluator.
package alegp_pkg;

  localparam int SQ_CELLS = 31;
  localparam int RAD_W    = 2 * SQ_CELLS;
  localparam int ROOT_W   = SQ_CELLS;
  localparam int REM_W    = ROOT_W + 4;

  localparam logic [63:0] LIM_Q32  = 64'h01FF_FFFF_FFFF_FFFF;
  localparam logic [31:0] ONE_Q30  = 32'h4000_0000;
  localparam logic signed [63:0] OUT_MAX = 64'sh0000_1FFF_FFFF_FFFF;
  localparam logic signed [63:0] OUT_MIN = -64'sh0000_2000_0000_0000;

  typedef struct packed {
    logic              valid;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  rad;
  } sq_cell_t;

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    mag64 = v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [63:0] with_sign(input logic [63:0] m, input logic neg);
    with_sign = neg ? -$signed(m) : $signed(m);
  endfunction

endpackage

// ===== hw/rtl/alegp_sq_cell.sv =====
// One cell of the square-root chain: settles one root bit and passes the remainder on.
module alegp_sq_cell
  import alegp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  sq_cell_t c_in,
  output sq_cell_t c_out
);

  sq_cell_t         c_r;
  logic [REM_W-1:0] rem2;
  logic [REM_W-1:0] trial;

  always_comb begin
    rem2  = {c_in.rem[REM_W-3:0], c_in.rad[RAD_W-1 -: 2]};
    trial = REM_W'({c_in.root, 2'b01});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r.valid <= 1'b0;
    end else begin
      c_r.valid <= c_in.valid;
    end
    c_r.rad <= {c_in.rad[RAD_W-3:0], 2'b00};
    if (rem2 >= trial) begin
      c_r.rem  <= rem2 - trial;
      c_r.root <= {c_in.root[ROOT_W-2:0], 1'b1};
    end else begin
      c_r.rem  <= rem2;
      c_r.root <= {c_in.root[ROOT_W-2:0], 1'b0};
    end
  end

  assign c_out = c_r;

endmodule

// ===== hw/rtl/alegp_mul.sv =====
// Rounded Q30 product of a 64-bit and a 31-bit magnitude, built from two partial products.
module alegp_mul
  import alegp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [30:0] b,
  output logic        busy,
  output logic        done,
  output logic [63:0] result
);

  logic        busy_r;
  logic        done_r;
  logic [1:0]  ph_r;
  logic [63:0] a_r;
  logic [30:0] b_r;
  logic [62:0] plo_r;
  logic [62:0] phi_r;
  logic [63:0] res_r;
  logic [95:0] sum;

  assign sum = 96'({phi_r, 32'b0}) + 96'(plo_r) + 96'(64'd1 << 29);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        a_r    <= a;
        b_r    <= b;
        busy_r <= 1'b1;
        ph_r   <= 2'd0;
      end else if (busy_r) begin
        unique case (ph_r)
          2'd0: begin
            plo_r <= 63'(a_r[31:0]) * 63'(b_r);
            ph_r  <= 2'd1;
          end
          2'd1: begin
            phi_r <= 63'(a_r[63:32]) * 63'(b_r);
            ph_r  <= 2'd2;
          end
          default: begin
            res_r  <= sum[93:30];
            busy_r <= 1'b0;
            done_r <= 1'b1;
            ph_r   <= 2'd0;
          end
        endcase
      end
    end
  end

  assign busy   = busy_r;
  assign done   = done_r;
  assign result = res_r;

endmodule

// ===== hw/rtl/alegp_div.sv =====
// Rounded division of a 64-bit magnitude by a small integer, four quotient bits a cycle.
module alegp_div
  import alegp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [5:0]  den,
  output logic        busy,
  output logic        done,
  output logic [63:0] quot
);

  logic        busy_r;
  logic        done_r;
  logic [3:0]  cnt_r;
  logic [63:0] q_r;
  logic [6:0]  rem_r;
  logic [5:0]  den_r;
  logic [63:0] q_n;
  logic [6:0]  rem_n;

  always_comb begin
    q_n   = q_r;
    rem_n = rem_r;
    for (int j = 0; j < 4; j++) begin
      rem_n = {rem_n[5:0], q_n[63]};
      q_n   = {q_n[62:0], 1'b0};
      if (rem_n >= {1'b0, den_r}) begin
        rem_n   = rem_n - {1'b0, den_r};
        q_n[0]  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 4'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        q_r    <= num + 64'(den >> 1);
        rem_r  <= 7'd0;
        den_r  <= den;
        cnt_r  <= 4'd15;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        q_r   <= q_n;
        rem_r <= rem_n;
        if (cnt_r == 4'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 4'd1;
        end
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = q_r;

endmodule

// ===== hw/rtl/associated_legendre_eval.sv =====
// Associated Legendre function P_l^m(mu) evaluator: sequencer, square-root chain and units.
//
// The block takes one item on the in_ channel (degree, signed order, argument mu in
// Q1.30) and returns one item on the out_ channel: P_l^m(mu) in Q21.24 and a flag
// that is set when the value was clipped. Arguments beyond plus or minus one are
// clamped first. Items are worked one at a time; in_ready is high only while the
// sequencer is idle.
// The work per item grows with |m|, and with l-|m| when the degree is larger; a negative
// order adds two divisions and a multiplication for each unit of |m|. An item whose order
// exceeds its degree, or whose degree exceeds MAX_DEGREE, goes straight to the output
// stage. The 31-cell square-root chain yields sqrt(1 - mu^2), and the shared divider,
// which yields four quotient bits a cycle, serves the negative-order scaling and the
// recurrence.
// The result sits in an output register, so a stalled receiver holds up only the final
// step of the next item; the sequencer waits in S_FIN until the register is free.
// Synchronous reset clears the sequencer and the output valid flag.
module associated_legendre_eval
  import alegp_pkg::*;
#(
  parameter int MAX_DEGREE = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         in_degree,
  input  logic signed [4:0]  in_order,
  input  logic signed [31:0] in_argument,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [45:0] out_value,
  output logic               out_saturated
);

  typedef enum logic [4:0] {
    S_IDLE, S_SQ, S_SQ_GO, S_SQ_W, S_SMUL_GO, S_SMUL_W, S_SPOS, S_SDIV1_GO,
    S_SDIV1_W, S_SNMUL, S_SDIV2_GO, S_SDIV2_W, S_P0, S_P1_GO, S_P1_W, S_P1SC,
    S_RMUL_GO, S_RMUL_W, S_RNUM, S_RDIV_GO, S_RDIV_W, S_FIN
  } state_t;

  state_t state_r;

  logic [3:0]         l_r;
  logic [4:0]         am_r;
  logic               neg_r;
  logic [30:0]        xm_r;
  logic               xneg_r;
  logic [61:0]        sq_r;
  logic [30:0]        s_r;
  logic [63:0]        v_r;
  logic [4:0]         i_r;
  logic [4:0]         ll_r;
  logic signed [63:0] p0_r;
  logic signed [63:0] p1_r;
  logic signed [63:0] q_r;
  logic signed [63:0] t_r;
  logic signed [63:0] num_r;
  logic               ovf_r;

  logic               out_valid_r;
  logic signed [45:0] out_value_r;
  logic               out_sat_r;

  logic signed [31:0] xc;
  logic [30:0]        xmag;
  logic [4:0]         am_in;
  logic               bad_in;
  logic [5:0]         kodd;
  logic [5:0]         a_div;
  logic [5:0]         k_p1;
  logic [5:0]         c1;
  logic [5:0]         c2;
  logic [5:0]         am2;
  logic [69:0]        prod_pos;
  logic [69:0]        prod_p1;
  logic [63:0]        p1_mag;
  logic signed [63:0] p1_val;
  logic [63:0]        p0_neg;
  logic signed [63:0] p0_val;
  logic [63:0]        r_clip;
  logic               r_ovf;
  logic signed [63:0] r_val;
  logic [63:0]        mg;
  logic signed [63:0] qs;
  logic signed [63:0] fin_v;
  logic               fin_ovf;

  sq_cell_t chain [0:SQ_CELLS];

  logic        mul_start, mul_busy, mul_done;
  logic [63:0] mul_a, mul_res;
  logic [30:0] mul_b;
  logic        div_start, div_busy, div_done;
  logic [63:0] div_num, div_q;
  logic [5:0]  div_den;

  always_comb begin
    xc = in_argument;
    if (in_argument > $signed(ONE_Q30)) begin
      xc = $signed(ONE_Q30);
    end else if (in_argument < -$signed(ONE_Q30)) begin
      xc = -$signed(ONE_Q30);
    end
    xmag   = xc[31] ? 31'(-xc) : 31'(xc);
    am_in  = in_order[4] ? 5'(-in_order) : 5'(in_order);
    bad_in = (int'(in_degree) > MAX_DEGREE) || (am_in > {1'b0, in_degree});
  end

  always_comb begin
    kodd   = {i_r, 1'b1} - 6'd2;
    a_div  = 6'(l_r) - 6'(am_r) + kodd;
    k_p1   = {am_r, 1'b1};
    c1     = {ll_r, 1'b1} - 6'd2;
    c2     = 6'(ll_r) + 6'(am_r) - 6'd1;
    am2    = 6'(am_r) + 6'd2;

    prod_pos = 70'(v_r) * 70'(kodd);

    prod_p1 = 70'(mag64(t_r)) * 70'(k_p1);
    p1_mag  = (prod_p1 > 70'(LIM_Q32)) ? LIM_Q32 : prod_p1[63:0];
    p1_val  = with_sign(p1_mag, t_r[63]);

    p0_neg = (v_r + (64'd1 << 27)) >> 28;
    p0_val = neg_r ? $signed(p0_neg) : with_sign(v_r, am_r[0]);

    r_ovf  = div_q > LIM_Q32;
    r_clip = r_ovf ? LIM_Q32 : div_q;
    r_val  = with_sign(r_clip, num_r[63]);

    mg      = (mag64(q_r) + 64'd128) >> 8;
    qs      = with_sign(mg, q_r[63]);
    fin_ovf = ovf_r;
    fin_v   = qs;
    if (ovf_r) begin
      fin_v = qs[63] ? OUT_MIN : OUT_MAX;
    end else if (qs > OUT_MAX) begin
      fin_v   = OUT_MAX;
      fin_ovf = 1'b1;
    end else if (qs < OUT_MIN) begin
      fin_v   = OUT_MIN;
      fin_ovf = 1'b1;
    end
  end

  always_comb begin
    chain[0].valid = (state_r == S_SQ_GO);
    chain[0].rem   = '0;
    chain[0].root  = '0;
    chain[0].rad   = RAD_W'(64'd1 << 60) - sq_r;
  end

  for (genvar g = 0; g < SQ_CELLS; g++) begin : g_sq
    alegp_sq_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .c_in  (chain[g]),
      .c_out (chain[g+1])
    );
  end

  assign mul_start = (state_r == S_SMUL_GO) || (state_r == S_P1_GO) || (state_r == S_RMUL_GO);
  assign mul_a     = (state_r == S_SMUL_GO) ? v_r :
                     (state_r == S_P1_GO) ? mag64(p0_r) : mag64(p1_r);
  assign mul_b     = (state_r == S_SMUL_GO) ? s_r : xm_r;

  alegp_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .busy   (mul_busy),
    .done   (mul_done),
    .result (mul_res)
  );

  assign div_start = (state_r == S_SDIV1_GO) || (state_r == S_SDIV2_GO) ||
                     (state_r == S_RDIV_GO);
  assign div_num   = (state_r == S_RDIV_GO) ? mag64(num_r) : v_r;
  assign div_den   = (state_r == S_SDIV1_GO) ? a_div :
                     (state_r == S_SDIV2_GO) ? a_div + 6'd1 : 6'(ll_r) - 6'(am_r);

  alegp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            l_r    <= in_degree;
            am_r   <= am_in;
            neg_r  <= in_order[4];
            xm_r   <= xmag;
            xneg_r <= xc[31];
            ovf_r  <= 1'b0;
            q_r    <= '0;
            state_r <= bad_in ? S_FIN : S_SQ;
          end
        end
        S_SQ: begin
          sq_r    <= 62'(xm_r) * 62'(xm_r);
          state_r <= S_SQ_GO;
        end
        S_SQ_GO: state_r <= S_SQ_W;
        S_SQ_W: begin
          if (chain[SQ_CELLS].valid) begin
            s_r     <= chain[SQ_CELLS].root;
            v_r     <= neg_r ? (64'd1 << 60) : (64'd1 << 32);
            i_r     <= 5'd1;
            state_r <= (am_r == 5'd0) ? S_P0 : S_SMUL_GO;
          end
        end
        S_SMUL_GO: state_r <= S_SMUL_W;
        S_SMUL_W: begin
          if (mul_done) begin
            v_r     <= mul_res;
            state_r <= neg_r ? S_SDIV1_GO : S_SPOS;
          end
        end
        S_SPOS: begin
          if (prod_pos > 70'(LIM_Q32)) begin
            v_r   <= LIM_Q32;
            ovf_r <= 1'b1;
          end else begin
            v_r <= prod_pos[63:0];
          end
          i_r     <= i_r + 5'd1;
          state_r <= (i_r == am_r) ? S_P0 : S_SMUL_GO;
        end
        S_SDIV1_GO: state_r <= S_SDIV1_W;
        S_SDIV1_W: begin
          if (div_done) begin
            v_r     <= div_q;
            state_r <= S_SNMUL;
          end
        end
        S_SNMUL: begin
          v_r     <= 64'(v_r * 64'(kodd));
          state_r <= S_SDIV2_GO;
        end
        S_SDIV2_GO: state_r <= S_SDIV2_W;
        S_SDIV2_W: begin
          if (div_done) begin
            v_r     <= div_q;
            i_r     <= i_r + 5'd1;
            state_r <= (i_r == am_r) ? S_P0 : S_SMUL_GO;
          end
        end
        S_P0: begin
          p0_r    <= p0_val;
          q_r     <= p0_val;
          state_r <= ({1'b0, l_r} > am_r) ? S_P1_GO : S_FIN;
        end
        S_P1_GO: state_r <= S_P1_W;
        S_P1_W: begin
          if (mul_done) begin
            t_r     <= with_sign(mul_res, p0_r[63] ^ xneg_r);
            state_r <= S_P1SC;
          end
        end
        S_P1SC: begin
          if (prod_p1 > 70'(LIM_Q32)) begin
            ovf_r <= 1'b1;
          end
          p1_r    <= p1_val;
          q_r     <= p1_val;
          ll_r    <= am2[4:0];
          state_r <= (am2 > 6'(l_r)) ? S_FIN : S_RMUL_GO;
        end
        S_RMUL_GO: state_r <= S_RMUL_W;
        S_RMUL_W: begin
          if (mul_done) begin
            t_r     <= with_sign(mul_res, p1_r[63] ^ xneg_r);
            state_r <= S_RNUM;
          end
        end
        S_RNUM: begin
          num_r   <= 64'(t_r * $signed(64'(c1))) - 64'(p0_r * $signed(64'(c2)));
          state_r <= S_RDIV_GO;
        end
        S_RDIV_GO: state_r <= S_RDIV_W;
        S_RDIV_W: begin
          if (div_done) begin
            if (r_ovf) begin
              ovf_r <= 1'b1;
            end
            p0_r    <= p1_r;
            p1_r    <= r_val;
            q_r     <= r_val;
            ll_r    <= ll_r + 5'd1;
            state_r <= (ll_r == 5'(l_r)) ? S_FIN : S_RMUL_GO;
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_value_r <= fin_v[45:0];
            out_sat_r   <= fin_ovf;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;
  assign out_saturated = out_sat_r;

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != S_IDLE))
    else $error("sequencer stayed idle after accepting an item");

  a_root_only_when_waited: assert property (@(posedge clk) disable iff (!rst_n)
    chain[SQ_CELLS].valid |-> (state_r == S_SQ_W))
    else $error("square root emerged while the sequencer was not waiting for it");

  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_busy && div_busy))
    else $error("multiplier and divider busy together");

  a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_SDIV1_W || state_r == S_SDIV2_W || state_r == S_RDIV_W))
    else $error("divider finished outside a divider wait state");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_sat_r) |->
      (out_value_r == OUT_MAX[45:0] || out_value_r == OUT_MIN[45:0]))
    else $error("saturated item not at an output limit");

endmodule

// ===== tb/associated_legendre_eval_checker.sv =====
// Channel monitor, fixed-point predictor and result scoreboard of the associated Legendre evaluator.
`timescale 1ns / 100ps
module associated_legendre_eval_checker
  import alegp_pkg::*;
#(
  parameter int MAX_DEGREE = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [3:0]         in_degree,
  input  logic signed [4:0]  in_order,
  input  logic signed [31:0] in_argument,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [45:0] out_value,
  input  logic               out_saturated,
  output int                 fail_count,
  output int                 pending,
  output int                 items_seen,
  output int                 clipped_seen
);

  typedef struct {
    logic signed [45:0] value;
    logic               saturated;
  } legendre_res_t;

  legendre_res_t expected_values[$];

  function automatic logic [63:0] mul_round(input logic [63:0] a, input logic [63:0] b,
                                            input int sh);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b} + (128'd1 << (sh - 1));
    return 64'(p >> sh);
  endfunction

  function automatic logic [63:0] magn(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [63:0] signed_of(input logic [63:0] m, input logic ng);
    return ng ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [63:0] div_round(input logic [63:0] n, input logic [63:0] d);
    return (n + d / 2) / d;
  endfunction

  function automatic logic signed [63:0] mul_arg(input logic signed [63:0] p,
                                                 input logic signed [63:0] x);
    return signed_of(mul_round(magn(p), magn(x), 30), p[63] ^ x[63]);
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [63:0] d);
    logic [63:0] res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > d) bt = bt >> 2;
    while (bt != 0) begin
      if (d >= res + bt) begin
        d = d - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic legendre_res_t legendre_value(input logic [3:0] deg,
                                                   input logic signed [4:0] ord,
                                                   input logic signed [31:0] arg);
    legendre_res_t res;
    logic signed [63:0] x, p0, p1, q, num, c1, c2;
    logic [63:0] s, v, a, r, mg, l, am, ii, ll;
    logic ng, ovf;
    res.value = '0;
    res.saturated = 1'b0;
    x = 64'(arg);
    if (x > $signed({32'd0, ONE_Q30})) x = $signed({32'd0, ONE_Q30});
    if (x < -$signed({32'd0, ONE_Q30})) x = -$signed({32'd0, ONE_Q30});
    l = 64'(deg);
    ng = ord[4];
    am = ng ? 64'(-int'(ord)) : 64'(int'(ord));
    ovf = 1'b0;
    if (l > MAX_DEGREE || am > l) return res;
    s = floor_sqrt((64'd1 << 60) - 64'(x * x));
    if (ng) begin
      v = 64'd1 << 60;
      for (ii = 1; ii <= am; ii++) begin
        a = l - am + 2 * ii - 1;
        v = mul_round(v, s, 30);
        v = div_round(v, a);
        v = v * (2 * ii - 1);
        v = div_round(v, a + 1);
      end
      p0 = $signed((v + (64'd1 << 27)) >> 28);
    end else begin
      v = 64'd1 << 32;
      for (ii = 1; ii <= am; ii++) begin
        v = mul_round(v, s, 30);
        if (v > LIM_Q32 / (2 * ii - 1)) begin
          v = LIM_Q32;
          ovf = 1'b1;
        end else begin
          v = v * (2 * ii - 1);
        end
      end
      p0 = signed_of(v, am[0]);
    end
    q = p0;
    if (l > am) begin
      p1 = mul_arg(p0, x);
      mg = magn(p1);
      if (mg > LIM_Q32 / (2 * am + 1)) begin
        ovf = 1'b1;
        mg = LIM_Q32;
      end else begin
        mg = mg * (2 * am + 1);
      end
      p1 = signed_of(mg, p1[63]);
      q = p1;
      for (ll = am + 2; ll <= l; ll++) begin
        c1 = $signed(2 * ll - 1);
        c2 = $signed(ll + am - 1);
        num = c1 * mul_arg(p1, x) - c2 * p0;
        r = div_round(magn(num), ll - am);
        if (r > LIM_Q32) begin
          r = LIM_Q32;
          ovf = 1'b1;
        end
        q = signed_of(r, num[63]);
        p0 = p1;
        p1 = q;
      end
    end
    mg = (magn(q) + 128) >> 8;
    q = signed_of(mg, q[63]);
    if (ovf) begin
      q = q[63] ? OUT_MIN : OUT_MAX;
    end else if (q > OUT_MAX) begin
      q = OUT_MAX;
      ovf = 1'b1;
    end else if (q < OUT_MIN) begin
      q = OUT_MIN;
      ovf = 1'b1;
    end
    res.value = q[45:0];
    res.saturated = ovf;
    return res;
  endfunction

  always @(posedge clk) begin
    legendre_res_t exp_res;
    int errs;
    errs = 0;
    if (!rst_n) begin
      expected_values.delete();
      fail_count   <= 0;
      items_seen   <= 0;
      clipped_seen <= 0;
      pending      <= 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_values.push_back(legendre_value(in_degree, in_order, in_argument));
        items_seen <= items_seen + 1;
      end
      if (out_valid && out_ready) begin
        if (expected_values.size() == 0) begin
          $error("result item with no expectation: value %0d", out_value);
          errs = errs + 1;
        end else begin
          exp_res = expected_values.pop_front();
          if (out_saturated) clipped_seen <= clipped_seen + 1;
          if (exp_res.value !== out_value) begin
            $error("value: expected %0d, actual %0d", exp_res.value, out_value);
            errs = errs + 1;
          end
          if (exp_res.saturated !== out_saturated) begin
            $error("saturated: expected %0d, actual %0d", exp_res.saturated, out_saturated);
            errs = errs + 1;
          end
        end
      end
      fail_count <= fail_count + errs;
      pending    <= expected_values.size();
    end
  end

endmodule

// ===== tb/associated_legendre_eval_tb.sv =====
// Top-level testbench of the associated Legendre evaluator: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module associated_legendre_eval_tb;
  import alegp_pkg::*;

  localparam int N_RANDOM = 900;
  localparam int N_CALM   = 100;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [3:0]         in_degree = '0;
  logic signed [4:0]  in_order = '0;
  logic signed [31:0] in_argument = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [45:0] out_value;
  logic               out_saturated;
  int                 fail_count, pending, items_seen, clipped_seen;
  logic               calm = 1'b0;
  int                 ready_run = 0;

  always #4 clk = ~clk;

  associated_legendre_eval #(.MAX_DEGREE(8)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_degree(in_degree), .in_order(in_order), .in_argument(in_argument),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_value(out_value), .out_saturated(out_saturated)
  );

  associated_legendre_eval_checker #(.MAX_DEGREE(8)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_degree(in_degree), .in_order(in_order), .in_argument(in_argument),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_value(out_value), .out_saturated(out_saturated),
    .fail_count(fail_count), .pending(pending),
    .items_seen(items_seen), .clipped_seen(clipped_seen)
  );

  always @(posedge clk) begin
    if (calm) begin
      out_ready <= 1'b1;
    end else if (ready_run == 0) begin
      out_ready <= $urandom_range(0, 2) != 0;
      ready_run <= $urandom_range(1, 11);
    end else begin
      ready_run <= ready_run - 1;
    end
  end

  task automatic send_item(input logic [3:0] deg, input logic signed [4:0] ord,
                           input logic signed [31:0] arg);
    int gap;
    in_valid <= 1'b1;
    in_degree <= deg;
    in_order <= ord;
    in_argument <= arg;
    do @(posedge clk); while (!in_ready);
    if (!calm && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    int deg, ord, wait_cycles;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(4'd0, 5'sd0, 32'sd0);
    send_item(4'd8, 5'sd8, 32'sd0);
    send_item(4'd8, -5'sd8, 32'sd0);
    send_item(4'd8, 5'sd0, 32'h4000_0000);
    send_item(4'd8, 5'sd0, -32'sh4000_0000);
    send_item(4'd8, 5'sd3, 32'h7FFF_FFFF);
    send_item(4'd8, -5'sd3, 32'h8000_0000);
    send_item(4'd8, 5'sd8, 32'h2000_0000);
    send_item(4'd8, -5'sd8, -32'sh2000_0000);
    send_item(4'd8, 5'sd1, 32'h3FFF_FFFF);
    send_item(4'd8, -5'sd1, 32'h0000_0001);
    send_item(4'd3, 5'sd4, 32'h1000_0000);
    send_item(4'd3, -5'sd4, 32'h1000_0000);
    send_item(4'd0, 5'sd15, 32'h1000_0000);
    send_item(4'd0, -5'sd16, 32'h1000_0000);
    send_item(4'd9, 5'sd0, 32'h1000_0000);
    send_item(4'd15, -5'sd1, 32'hFFFF_FFFF);
    send_item(4'd1, 5'sd1, 32'sd0);
    send_item(4'd1, -5'sd1, 32'h2D41_3CCD);
    send_item(4'd5, 5'sd2, -32'sh2D41_3CCD);
    send_item(4'd7, -5'sd7, 32'h4000_0000);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM - N_CALM) calm <= 1'b1;
      if ($urandom_range(0, 9) < 8) begin
        deg = $urandom_range(0, 8);
        ord = $urandom_range(0, 2 * deg) - deg;
        if ($urandom_range(0, 5) == 0) wait_cycles = 32'h4000_0000 - $urandom_range(0, 3);
        else wait_cycles = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
        if ($urandom_range(0, 9) == 0) wait_cycles = -wait_cycles;
        send_item(4'(deg), 5'(ord), 32'(wait_cycles));
      end else begin
        send_item(4'($urandom), 5'($urandom), 32'($urandom));
      end
    end
    in_valid <= 1'b0;

    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (400) @(posedge clk);
    $display("Sent %0d items over all degrees, orders and clamped arguments; %0d came back clipped.",
             items_seen, clipped_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("associated_legendre_eval test passed");
    end else begin
      $display("associated_legendre_eval test failed");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("associated_legendre_eval test failed");
    $finish;
  end

endmodule
